FILE: hw/rtl/srft_pkg.sv
package srft_pkg;

	localparam int MODULUS_BITS = 40;
	localparam int ADDR_W = 3;
	localparam logic [ADDR_W-1:0] REG_MODULUS = 3'd0;
	localparam logic [MODULUS_BITS-1:0] MODULUS_RESET = 40'd4;
	localparam int CNT_W = 32;

	typedef struct packed {
		logic busy;
		logic done;
	} stat_t;

	typedef struct packed {
		logic [31:0] gcd_count;
		logic [31:0] tried_count;
		logic [39:0] cofactor;
		logic [39:0] factor;
		logic        factor_found;
		logic [20:0] excess;
		logic [19:0] root;
		logic        square_residue;
	} result_t;

endpackage

FILE: hw/rtl/srft_divider.sv
module srft_divider #(
	parameter int W = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output srft_pkg::stat_t stat,
	output logic [W-1:0] quotient,
	output logic [W-1:0] remainder
);

	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  quo_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    trial;

	assign trial = {rem_q, quo_q[W-1]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[W-2:0], quo_q[W-1]};
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

FILE: hw/rtl/square_residue_factor_test.sv
// Square residue factor test.
// A candidate y arrives as one beat on the s_axis group; tdata holds candidate.
// The block computes r = y*y mod c, x = floor(sqrt(r)) and the excess r - x*x.
// When the excess is zero and (y - x) mod c is nonzero, Euclid's gcd of c and
// y - x runs; a gcd other than 1 and c gives a factor, c / factor the cofactor.
// One result beat leaves on the m_axis group with running saturating counts.
// Modulus: APB address 0; the user must write it only while idle (not enforced).
// All remainders and the cofactor use one bit-serial restoring divider of 64
// steps, started in a start state and awaited in a wait state; the root is
// found bit-serially by a restoring square root. When the residue is not a
// square the result follows the root; else y is divided by c next and, when
// a gcd runs, one division per Euclid step and one for the cofactor follow.
// A modulus of zero skips the squaring division and runs no gcd.
// One item is worked at a time; s_axis_tready is high only when the block is
// idle and the output register is empty. The result stays in the output
// register while m_axis_tready is low. Reset clears the counters, sets the
// modulus to 4 and empties the output register.
module square_residue_factor_test (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [srft_pkg::ADDR_W-1:0] paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// candidate[25:0], zero fill to 32 bits
	input  logic [31:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// square_residue[0], root[20:1], excess[41:21], factor_found[42],
	// factor[82:43], cofactor[122:83], tried_count[154:123], gcd_count[186:155]
	output logic [191:0] m_axis_tdata
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_SQ   = 4'd1;
	localparam logic [3:0] ST_SQW  = 4'd2;
	localparam logic [3:0] ST_ROOT = 4'd3;
	localparam logic [3:0] ST_YM   = 4'd4;
	localparam logic [3:0] ST_YMW  = 4'd5;
	localparam logic [3:0] ST_GCD  = 4'd6;
	localparam logic [3:0] ST_GCDW = 4'd7;
	localparam logic [3:0] ST_COF  = 4'd8;
	localparam logic [3:0] ST_COFW = 4'd9;
	localparam logic [3:0] ST_OUT  = 4'd10;

	logic [srft_pkg::MODULUS_BITS-1:0] modulus_q;
	logic [3:0]  state_q;
	logic [25:0] y_q;
	logic [63:0] r_q;
	logic [63:0] rem_q;
	logic [63:0] res_q;
	logic [5:0]  rcnt_q;
	logic [63:0] ga_q;
	logic [63:0] gb_q;
	logic [31:0] tried_q;
	logic [31:0] gcdn_q;
	logic        found_q;
	logic        out_v_q;
	srft_pkg::result_t out_q;

	logic        div_start;
	logic [63:0] div_a;
	logic [63:0] div_b;
	srft_pkg::stat_t div_stat;
	logic [63:0] div_quo;
	logic [63:0] div_rem;
	logic [63:0] cmod;
	logic [63:0] rtrial;
	logic [63:0] bitv;
	logic [63:0] dval;
	logic [63:0] root_rem;

	assign cmod = 64'(modulus_q);

	srft_divider #(.W(64)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_a),
		.divisor   (div_b),
		.stat      (div_stat),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	assign pready = 1'b1;
	assign prdata = (paddr == srft_pkg::REG_MODULUS) ? cmod : 64'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= srft_pkg::MODULUS_RESET;
		end else if (psel && penable && pwrite && paddr == srft_pkg::REG_MODULUS) begin
			modulus_q <= pwdata[srft_pkg::MODULUS_BITS-1:0];
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE) && !out_v_q;

	always_comb begin
		div_start = 1'b0;
		div_a = 64'(y_q) * 64'(y_q);
		div_b = cmod;
		unique case (state_q)
			ST_SQ:  div_start = 1'b1;
			ST_YM: begin
				div_start = 1'b1;
				div_a = 64'(y_q);
			end
			ST_GCD: begin
				div_start = 1'b1;
				div_a = ga_q;
				div_b = gb_q;
			end
			ST_COF: begin
				div_start = 1'b1;
				div_a = cmod;
				div_b = ga_q;
			end
			default: ;
		endcase
	end

	assign bitv     = 64'd1 << {rcnt_q, 1'b0};
	assign rtrial   = res_q + bitv;
	assign root_rem = (rem_q >= rtrial) ? rem_q - rtrial : rem_q;
	assign dval     = (div_rem >= res_q) ? div_rem - res_q : div_rem + cmod - res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_v_q <= 1'b0;
			tried_q <= '0;
			gcdn_q  <= '0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) out_v_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
					state_q <= ST_SQ;
					if (tried_q != '1) tried_q <= tried_q + 1'b1;
				end
				ST_SQ: state_q <= (cmod == 64'd0) ? ST_ROOT : ST_SQW;
				ST_SQW: if (div_stat.done) state_q <= ST_ROOT;
				ST_ROOT: if (rcnt_q == 6'd0) begin
					if (root_rem == 64'd0 && cmod != 64'd0) state_q <= ST_YM;
					else state_q <= ST_OUT;
				end
				ST_YM: state_q <= ST_YMW;
				ST_YMW: if (div_stat.done) begin
					state_q <= (dval == 64'd0) ? ST_OUT : ST_GCD;
					if (dval != 64'd0 && gcdn_q != '1) gcdn_q <= gcdn_q + 1'b1;
				end
				ST_GCD: state_q <= ST_GCDW;
				ST_GCDW: if (div_stat.done) begin
					if (div_rem == 64'd0) state_q <= ST_COF;
					else state_q <= ST_GCD;
				end
				ST_COF: state_q <= ST_COFW;
				ST_COFW: if (div_stat.done) state_q <= ST_OUT;
				ST_OUT: begin
					out_v_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				y_q     <= s_axis_tdata[25:0];
				found_q <= 1'b0;
				r_q     <= '0;
				rem_q   <= '0;
				res_q   <= '0;
				rcnt_q  <= 6'd31;
			end
			ST_SQW: if (div_stat.done) rem_q <= div_rem;
			ST_ROOT: begin
				if (rem_q >= rtrial) begin
					rem_q <= rem_q - rtrial;
					res_q <= (res_q >> 1) + bitv;
				end else begin
					res_q <= res_q >> 1;
				end
				rcnt_q <= rcnt_q - 1'b1;
			end
			ST_YMW: if (div_stat.done) begin
				ga_q <= cmod;
				gb_q <= dval;
			end
			ST_GCDW: if (div_stat.done) begin
				ga_q <= gb_q;
				gb_q <= div_rem;
			end
			ST_COFW: if (div_stat.done) begin
				r_q     <= div_quo;
				found_q <= (ga_q != 64'd1) && (ga_q != cmod);
			end
			default: ;
		endcase
		if (state_q == ST_OUT) begin
			out_q.square_residue <= (rem_q == 64'd0);
			out_q.root           <= res_q[19:0];
			out_q.excess         <= rem_q[20:0];
			out_q.factor_found   <= found_q;
			out_q.factor         <= found_q ? ga_q[39:0] : 40'd0;
			out_q.cofactor       <= found_q ? r_q[39:0] : 40'd0;
			out_q.tried_count    <= tried_q;
			out_q.gcd_count      <= gcdn_q;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {5'd0, out_q};

endmodule

FILE: hw/rtl/srft_checker.sv
module srft_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [191:0] m_axis_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("input taken while a result waits");

	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[42] |-> m_axis_tdata[0])
		else $error("factor without a square residue");

	a_gcd: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[186:155] <= m_axis_tdata[154:123])
		else $error("more gcds than candidates");

endmodule

bind square_residue_factor_test srft_checker u_srft_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

FILE: verif/tb_square_residue_factor_test.sv
`timescale 1ns / 1ps

module tb_square_residue_factor_test;

	localparam longint LIMIT_CYCLES = 64'd20000000;
	localparam int     DRAIN_CYCLES = 20000;
	localparam int     N_RANDOM     = 600;

	typedef struct {
		logic        write_modulus;
		logic [39:0] modulus_value;
		logic [25:0] cand;
		logic        has_known;
		logic        known_sq;
		logic [19:0] known_root;
		logic [20:0] known_excess;
		logic        known_found;
	} row_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [srft_pkg::ADDR_W-1:0] paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic pready;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [191:0] m_axis_tdata;

	logic [39:0] cur_modulus;
	logic [31:0] tried_total;
	logic [31:0] gcd_total;
	srft_pkg::result_t residue_queue[$];
	logic known_queue[$];
	srft_pkg::result_t known_vals[$];
	int errors;
	int results_seen;
	int factors_seen;
	longint cycle_count;
	int send_idle_pct;
	int recv_idle_pct;
	row_t rows[$];

	square_residue_factor_test u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic logic [63:0] isqrt(logic [63:0] v);
		logic [63:0] rem, res, b;
		rem = v;
		res = 0;
		b = 64'd1 << 62;
		while (b > rem)
			b = b >> 2;
		while (b != 0) begin
			if (rem >= res + b) begin
				rem = rem - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic logic [63:0] euclid(logic [63:0] a, logic [63:0] b);
		logic [63:0] t;
		while (b != 0) begin
			t = a % b;
			a = b;
			b = t;
		end
		return a;
	endfunction

	function automatic srft_pkg::result_t predict_square_test(logic [25:0] y);
		srft_pkg::result_t p;
		logic [63:0] c, r, x, ex, ym, d, g, cf;
		c = {24'd0, cur_modulus};
		r = 0;
		p = '0;
		if (tried_total != 32'hFFFF_FFFF)
			tried_total = tried_total + 1;
		if (c != 0)
			r = ({38'd0, y} * {38'd0, y}) % c;
		x = isqrt(r);
		ex = r - x * x;
		if (ex == 0 && c != 0) begin
			ym = {38'd0, y} % c;
			d = (ym >= x) ? (ym - x) : (ym + c - x);
			if (d != 0) begin
				g = euclid(c, d);
				if (gcd_total != 32'hFFFF_FFFF)
					gcd_total = gcd_total + 1;
				if (g != 1 && g != c && g != 0) begin
					cf = c / g;
					p.factor_found = 1'b1;
					p.factor = g[39:0];
					p.cofactor = cf[39:0];
				end
			end
		end
		p.square_residue = (ex == 0);
		p.root = x[19:0];
		p.excess = ex[20:0];
		p.tried_count = tried_total;
		p.gcd_count = gcd_total;
		return p;
	endfunction

	task automatic write_modulus(logic [39:0] value);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= srft_pkg::REG_MODULUS;
		pwdata <= {24'd0, value};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cur_modulus = value;
	endtask

	task automatic wait_idle();
		while (residue_queue.size() != 0)
			@(posedge clk);
		repeat (200)
			@(posedge clk);
	endtask

	task automatic send_candidate(logic [25:0] y, logic has_known,
		srft_pkg::result_t known);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct)
			@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'd0, y};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		residue_queue.push_back(predict_square_test(y));
		known_queue.push_back(has_known);
		known_vals.push_back(known);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
	endtask

	always @(negedge clk) begin
		if (arst_n)
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		srft_pkg::result_t got, want, kv;
		logic kn;
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("CHECKS FAILED");
			$finish;
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[186:0];
			results_seen++;
			if (residue_queue.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
			end else begin
				want = residue_queue.pop_front();
				kn = known_queue.pop_front();
				kv = known_vals.pop_front();
				if (kn) begin
					if (got.square_residue !== kv.square_residue) begin
						$error("square_residue exp %0d got %0d", kv.square_residue,
							got.square_residue);
						errors++;
					end
					if (got.root !== kv.root) begin
						$error("root exp %0d got %0d", kv.root, got.root);
						errors++;
					end
					if (got.excess !== kv.excess) begin
						$error("excess exp %0d got %0d", kv.excess, got.excess);
						errors++;
					end
					if (got.factor_found !== kv.factor_found) begin
						$error("factor_found exp %0d got %0d", kv.factor_found,
							got.factor_found);
						errors++;
					end
				end
				if (want.factor_found)
					factors_seen++;
				if (got.square_residue !== want.square_residue) begin
					$error("square_residue exp %0d got %0d", want.square_residue,
						got.square_residue);
					errors++;
				end
				if (got.root !== want.root) begin
					$error("root exp %0d got %0d", want.root, got.root);
					errors++;
				end
				if (got.excess !== want.excess) begin
					$error("excess exp %0d got %0d", want.excess, got.excess);
					errors++;
				end
				if (got.factor_found !== want.factor_found) begin
					$error("factor_found exp %0d got %0d", want.factor_found,
						got.factor_found);
					errors++;
				end
				if (got.factor !== want.factor) begin
					$error("factor exp %0d got %0d", want.factor, got.factor);
					errors++;
				end
				if (got.cofactor !== want.cofactor) begin
					$error("cofactor exp %0d got %0d", want.cofactor, got.cofactor);
					errors++;
				end
				if (got.tried_count !== want.tried_count) begin
					$error("tried_count exp %0d got %0d", want.tried_count,
						got.tried_count);
					errors++;
				end
				if (got.gcd_count !== want.gcd_count) begin
					$error("gcd_count exp %0d got %0d", want.gcd_count, got.gcd_count);
					errors++;
				end
			end
		end
	end

	task automatic add_row(logic wm, logic [39:0] mv, logic [25:0] y, logic hk,
		logic sq, logic [19:0] rt, logic [20:0] ex, logic ff);
		row_t r;
		r.write_modulus = wm;
		r.modulus_value = mv;
		r.cand = y;
		r.has_known = hk;
		r.known_sq = sq;
		r.known_root = rt;
		r.known_excess = ex;
		r.known_found = ff;
		rows.push_back(r);
	endtask

	function automatic logic [39:0] pick_modulus(int k);
		logic [39:0] p, q;
		case (k)
			0: return 40'd4;
			1: return 40'hFF_FFFF_FFFF;
			2: return 40'd15;
			3: return 40'd1;
			4: return 40'd0;
			default: begin
				p = 40'($urandom_range(2000, 3));
				q = 40'($urandom_range(2000, 3));
				return p * q;
			end
		endcase
	endfunction

	initial begin
		srft_pkg::result_t kr;
		logic [39:0] m;
		logic [25:0] y;
		int phase;
		arst_n = 1'b0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		s_axis_tvalid = 0; s_axis_tdata = '0; m_axis_tready = 0;
		cur_modulus = srft_pkg::MODULUS_RESET;
		tried_total = 0;
		gcd_total = 0;
		errors = 0;
		results_seen = 0;
		factors_seen = 0;
		cycle_count = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (9)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset modulus 4: y=2 and y=3 both reach gcd 2, y=1 gives no gcd.
		add_row(0, 0, 26'd2, 1, 1, 20'd0, 21'd0, 1);
		add_row(0, 0, 26'd3, 1, 1, 20'd1, 21'd0, 1);
		add_row(0, 0, 26'd1, 1, 1, 20'd1, 21'd0, 0);
		add_row(0, 0, 26'h3FF_FFFF, 0, 0, 0, 0, 0);
		add_row(1, 40'd15, 26'd4, 1, 1, 20'd1, 21'd0, 1);
		add_row(0, 0, 26'd7, 1, 1, 20'd2, 21'd0, 1);
		add_row(0, 0, 26'd2, 1, 1, 20'd2, 21'd0, 0);
		add_row(0, 0, 26'd1, 1, 1, 20'd1, 21'd0, 0);
		add_row(0, 0, 26'd6, 1, 0, 20'd2, 21'd2, 0);
		add_row(1, 40'd0, 26'd5, 1, 1, 20'd0, 21'd0, 0);
		add_row(0, 0, 26'h3FF_FFFF, 1, 1, 20'd0, 21'd0, 0);
		add_row(1, 40'd1, 26'd9, 1, 1, 20'd0, 21'd0, 0);
		add_row(1, 40'hFF_FFFF_FFFF, 26'h3FF_FFFF, 0, 0, 0, 0, 0);
		add_row(0, 0, 26'h2AA_AAAA, 0, 0, 0, 0, 0);
		add_row(0, 0, 26'h155_5555, 0, 0, 0, 0, 0);
		add_row(1, 40'd77, 26'd9, 0, 0, 0, 0, 0);
		add_row(0, 0, 26'd13, 0, 0, 0, 0, 0);
		add_row(1, 40'd1000003 * 40'd999983, 26'h3FF_FFFF, 0, 0, 0, 0, 0);

		foreach (rows[i]) begin
			if (rows[i].write_modulus) begin
				wait_idle();
				write_modulus(rows[i].modulus_value);
			end
			kr = '0;
			kr.square_residue = rows[i].known_sq;
			kr.root = rows[i].known_root;
			kr.excess = rows[i].known_excess;
			kr.factor_found = rows[i].known_found;
			send_candidate(rows[i].cand, rows[i].has_known, kr);
		end

		for (phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 84 : 0;
			recv_idle_pct = (phase == 0) ? 84 : (phase == 1) ? 21 : 0;
			for (int s = 0; s < 4; s++) begin
				wait_idle();
				m = pick_modulus((phase * 4 + s) % 8);
				write_modulus(m);
				for (int i = 0; i < N_RANDOM / 12; i++) begin
					if ($urandom_range(3) == 0)
						y = 26'($urandom);
					else if (m > 2 && m < 40'd67108863 && $urandom_range(1))
						y = 26'($urandom_range(m - 1, 1) + ($urandom_range(1) ? m : 0));
					else
						y = 26'($urandom_range(4000, 1));
					send_candidate(y, 1'b0, '0);
				end
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES / 10)
			@(posedge clk);
		$display("Ran %0d candidate results over several moduli including 0, 1 and max;",
			results_seen);
		$display("%0d of them reported a nontrivial factor.", factors_seen);
		if (errors == 0 && residue_queue.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
